### hw/rtl/mi4_pkg.sv
`timescale 1ns / 1ps
package mi4_pkg;
    localparam int ELEM_W = 16;
    localparam int RES_W = 32;
    localparam int THR_W = 48;
    localparam int MIN_W = 2 * ELEM_W + 1;
    localparam int DET_W = 2 * MIN_W + 3;
    localparam int ADJ_W = ELEM_W + MIN_W + 2;
    localparam int SHIFT = 28;
    localparam int NUM_W = ADJ_W + SHIFT;
    localparam int QUO_W = NUM_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [3:0] {
        ST_LOAD, ST_DET_A, ST_DET_B, ST_DET_DONE, ST_ADJ_A, ST_ADJ_B,
        ST_DIV_START, ST_DIV_WAIT, ST_EMIT, ST_SING
    } state_t;

    typedef struct packed {
        logic       det_clear;
        logic       det_mul;
        logic       det_acc;
        logic [2:0] det_term;
        logic       det_latch;
        logic       adj_clear;
        logic       adj_mul;
        logic       adj_acc;
        logic [1:0] adj_term;
        logic [3:0] adj_index;
        logic       div_start;
        logic       out_load;
        logic       out_singular;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic singular;
        logic div_busy;
        logic div_done;
    } status_t;

    function automatic logic [19:0] adj_entry(input logic [3:0] k, input logic [1:0] t);
        logic [19:0] r;
        r = '0;
        unique case ({k, t})
            {4'd0, 2'd0}: r = {4'd5, 4'd10, 4'd15, 4'd11, 4'd14};
            {4'd0, 2'd1}: r = {4'd6, 4'd11, 4'd13, 4'd9, 4'd15};
            {4'd0, 2'd2}: r = {4'd7, 4'd9, 4'd14, 4'd10, 4'd13};
            {4'd1, 2'd0}: r = {4'd9, 4'd2, 4'd15, 4'd3, 4'd14};
            {4'd1, 2'd1}: r = {4'd10, 4'd3, 4'd13, 4'd1, 4'd15};
            {4'd1, 2'd2}: r = {4'd11, 4'd1, 4'd14, 4'd2, 4'd13};
            {4'd2, 2'd0}: r = {4'd13, 4'd2, 4'd7, 4'd3, 4'd6};
            {4'd2, 2'd1}: r = {4'd14, 4'd3, 4'd5, 4'd1, 4'd7};
            {4'd2, 2'd2}: r = {4'd15, 4'd1, 4'd6, 4'd2, 4'd5};
            {4'd3, 2'd0}: r = {4'd1, 4'd7, 4'd10, 4'd6, 4'd11};
            {4'd3, 2'd1}: r = {4'd2, 4'd5, 4'd11, 4'd7, 4'd9};
            {4'd3, 2'd2}: r = {4'd3, 4'd6, 4'd9, 4'd5, 4'd10};
            {4'd4, 2'd0}: r = {4'd6, 4'd8, 4'd15, 4'd11, 4'd12};
            {4'd4, 2'd1}: r = {4'd7, 4'd10, 4'd12, 4'd8, 4'd14};
            {4'd4, 2'd2}: r = {4'd4, 4'd11, 4'd14, 4'd10, 4'd15};
            {4'd5, 2'd0}: r = {4'd10, 4'd0, 4'd15, 4'd3, 4'd12};
            {4'd5, 2'd1}: r = {4'd11, 4'd2, 4'd12, 4'd0, 4'd14};
            {4'd5, 2'd2}: r = {4'd8, 4'd3, 4'd14, 4'd2, 4'd15};
            {4'd6, 2'd0}: r = {4'd14, 4'd0, 4'd7, 4'd3, 4'd4};
            {4'd6, 2'd1}: r = {4'd15, 4'd2, 4'd4, 4'd0, 4'd6};
            {4'd6, 2'd2}: r = {4'd12, 4'd3, 4'd6, 4'd2, 4'd7};
            {4'd7, 2'd0}: r = {4'd2, 4'd7, 4'd8, 4'd4, 4'd11};
            {4'd7, 2'd1}: r = {4'd3, 4'd4, 4'd10, 4'd6, 4'd8};
            {4'd7, 2'd2}: r = {4'd0, 4'd6, 4'd11, 4'd7, 4'd10};
            {4'd8, 2'd0}: r = {4'd7, 4'd8, 4'd13, 4'd9, 4'd12};
            {4'd8, 2'd1}: r = {4'd4, 4'd9, 4'd15, 4'd11, 4'd13};
            {4'd8, 2'd2}: r = {4'd5, 4'd11, 4'd12, 4'd8, 4'd15};
            {4'd9, 2'd0}: r = {4'd11, 4'd0, 4'd13, 4'd1, 4'd12};
            {4'd9, 2'd1}: r = {4'd8, 4'd1, 4'd15, 4'd3, 4'd13};
            {4'd9, 2'd2}: r = {4'd9, 4'd3, 4'd12, 4'd0, 4'd15};
            {4'd10, 2'd0}: r = {4'd15, 4'd0, 4'd5, 4'd1, 4'd4};
            {4'd10, 2'd1}: r = {4'd12, 4'd1, 4'd7, 4'd3, 4'd5};
            {4'd10, 2'd2}: r = {4'd13, 4'd3, 4'd4, 4'd0, 4'd7};
            {4'd11, 2'd0}: r = {4'd3, 4'd5, 4'd8, 4'd4, 4'd9};
            {4'd11, 2'd1}: r = {4'd0, 4'd7, 4'd9, 4'd5, 4'd11};
            {4'd11, 2'd2}: r = {4'd1, 4'd4, 4'd11, 4'd7, 4'd8};
            {4'd12, 2'd0}: r = {4'd4, 4'd10, 4'd13, 4'd9, 4'd14};
            {4'd12, 2'd1}: r = {4'd5, 4'd8, 4'd14, 4'd10, 4'd12};
            {4'd12, 2'd2}: r = {4'd6, 4'd9, 4'd12, 4'd8, 4'd13};
            {4'd13, 2'd0}: r = {4'd8, 4'd2, 4'd13, 4'd1, 4'd14};
            {4'd13, 2'd1}: r = {4'd9, 4'd0, 4'd14, 4'd2, 4'd12};
            {4'd13, 2'd2}: r = {4'd10, 4'd1, 4'd12, 4'd0, 4'd13};
            {4'd14, 2'd0}: r = {4'd12, 4'd2, 4'd5, 4'd1, 4'd6};
            {4'd14, 2'd1}: r = {4'd13, 4'd0, 4'd6, 4'd2, 4'd4};
            {4'd14, 2'd2}: r = {4'd14, 4'd1, 4'd4, 4'd0, 4'd5};
            {4'd15, 2'd0}: r = {4'd0, 4'd5, 4'd10, 4'd6, 4'd9};
            {4'd15, 2'd1}: r = {4'd1, 4'd6, 4'd8, 4'd4, 4'd10};
            {4'd15, 2'd2}: r = {4'd2, 4'd4, 4'd9, 4'd5, 4'd8};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [32:0] det_entry(input logic [2:0] t);
        logic [32:0] r;
        unique case (t)
            3'd0: r = {1'b0, 4'd0, 4'd5, 4'd1, 4'd4, 4'd10, 4'd15, 4'd11, 4'd14};
            3'd1: r = {1'b1, 4'd0, 4'd6, 4'd2, 4'd4, 4'd9, 4'd15, 4'd11, 4'd13};
            3'd2: r = {1'b0, 4'd0, 4'd7, 4'd3, 4'd4, 4'd9, 4'd14, 4'd10, 4'd13};
            3'd3: r = {1'b0, 4'd1, 4'd6, 4'd2, 4'd5, 4'd8, 4'd15, 4'd11, 4'd12};
            3'd4: r = {1'b1, 4'd1, 4'd7, 4'd3, 4'd5, 4'd8, 4'd14, 4'd10, 4'd12};
            3'd5: r = {1'b0, 4'd2, 4'd7, 4'd3, 4'd6, 4'd8, 4'd13, 4'd9, 4'd12};
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

### hw/rtl/mi4_if.sv
`timescale 1ns / 1ps
interface mi4_elem_if;
    logic                              valid;
    logic                              ready;
    logic signed [mi4_pkg::ELEM_W-1:0] element_value;
    logic [3:0]                        element_position;
    modport source(output valid, element_value, element_position, input ready);
    modport sink(input valid, element_value, element_position, output ready);
endinterface

interface mi4_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [mi4_pkg::RES_W-1:0] inverse_element;
    logic [3:0]                       result_position;
    logic                             singular;
    logic                             saturated;
    logic                             last;
    modport source(output valid, inverse_element, result_position, singular, saturated,
        last, input ready);
    modport sink(input valid, inverse_element, result_position, singular, saturated,
        last, output ready);
endinterface

interface mi4_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mi4_pkg::THR_W-1:0]  data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

### hw/rtl/mi4_divider.sv
`timescale 1ns / 1ps
module mi4_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mi4_pkg::NUM_W-1:0]    numerator,
    input  logic [mi4_pkg::DET_W-1:0]    divisor,
    output logic                         busy,
    output logic                         done,
    output logic [mi4_pkg::QUO_W-1:0]    quotient
);
    logic [mi4_pkg::NUM_W-1:0] num_reg, num_next;
    logic [mi4_pkg::DET_W:0]   rem_reg, rem_next;
    logic [mi4_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [mi4_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [mi4_pkg::DET_W:0]   shifted;
    logic [mi4_pkg::DET_W:0]   diff;

    assign shifted = {rem_reg[mi4_pkg::DET_W-1:0], num_reg[mi4_pkg::NUM_W-1]};
    assign diff = shifted - {1'b0, divisor};

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = numerator;
            rem_next = '0;
            quo_next = '0;
            cnt_next = mi4_pkg::CNT_W'(mi4_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[mi4_pkg::NUM_W-2:0], 1'b0};
            if (!diff[mi4_pkg::DET_W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[mi4_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[mi4_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mi4_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

### hw/rtl/mi4_datapath.sv
`timescale 1ns / 1ps
module mi4_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        store_we,
    input  logic [3:0]                  store_addr,
    input  logic [mi4_pkg::ELEM_W-1:0]  store_data,
    input  logic [mi4_pkg::THR_W-1:0]   threshold,
    input  logic [3:0]                  out_position,
    input  mi4_pkg::cmd_t               cmd,
    output mi4_pkg::status_t            status,
    output logic signed [mi4_pkg::RES_W-1:0] inverse_element,
    output logic [3:0]                  result_position,
    output logic                        singular,
    output logic                        saturated,
    output logic                        last
);
    localparam int EW = mi4_pkg::ELEM_W;
    localparam int MW = mi4_pkg::MIN_W;
    localparam int DW = mi4_pkg::DET_W;
    localparam int AW = mi4_pkg::ADJ_W;
    localparam int RW = mi4_pkg::RES_W;
    localparam int QW = mi4_pkg::QUO_W;

    logic signed [EW-1:0] store_reg [16];
    logic [32:0] dsel;
    logic [19:0] asel;
    logic signed [MW-1:0] m1_reg, m2_reg, am_reg;
    logic signed [EW-1:0] ae_reg;
    logic signed [2*MW-1:0] dprod_reg;
    logic signed [AW-1:0] aprod_reg;
    logic dneg_reg;
    logic signed [DW-1:0] det_reg;
    logic [DW-1:0] adet;
    logic det_neg;
    logic sing_reg;
    logic [AW-1:0] adj_mag;
    logic [mi4_pkg::NUM_W-1:0] numer;
    logic res_neg_reg;
    logic div_busy, div_done;
    logic [QW-1:0] quo;
    logic [QW-1:0] lim;
    logic signed [RW-1:0] val_reg;
    logic sat_reg, osing_reg, last_reg;
    logic [3:0] opos_reg;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_addr] <= store_data;
        end
    end

    assign dsel = mi4_pkg::det_entry(cmd.det_term);
    assign asel = mi4_pkg::adj_entry(cmd.adj_index, cmd.adj_term);

    always_ff @(posedge clk)
    begin
        if (cmd.det_mul)
        begin
            m1_reg <= MW'(store_reg[dsel[31:28]] * store_reg[dsel[27:24]])
                - MW'(store_reg[dsel[23:20]] * store_reg[dsel[19:16]]);
            m2_reg <= MW'(store_reg[dsel[15:12]] * store_reg[dsel[11:8]])
                - MW'(store_reg[dsel[7:4]] * store_reg[dsel[3:0]]);
            dneg_reg <= dsel[32];
        end
        if (cmd.det_acc)
        begin
            dprod_reg <= m1_reg * m2_reg;
        end
        if (cmd.det_clear)
        begin
            det_reg <= '0;
        end
        else if (cmd.det_latch)
        begin
            det_reg <= dneg_reg ? det_reg - DW'(dprod_reg) : det_reg + DW'(dprod_reg);
        end
        if (cmd.adj_mul)
        begin
            ae_reg <= store_reg[asel[19:16]];
            am_reg <= MW'(store_reg[asel[15:12]] * store_reg[asel[11:8]])
                - MW'(store_reg[asel[7:4]] * store_reg[asel[3:0]]);
        end
        if (cmd.adj_acc)
        begin
            aprod_reg <= AW'(ae_reg * am_reg);
        end
    end

    logic adj_add;
    assign adj_add = cmd.adj_mul && !cmd.adj_clear && (cmd.adj_term != 2'd0);

    logic signed [AW-1:0] adj_acc_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.adj_clear)
        begin
            adj_acc_reg <= '0;
        end
        else if (adj_add || cmd.div_start)
        begin
            adj_acc_reg <= adj_acc_reg + aprod_reg;
        end
    end

    assign det_neg = det_reg[DW-1];
    assign adet = det_neg ? DW'(-det_reg) : det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sing_reg <= 1'b0;
        end
        else if (cmd.det_clear)
        begin
            sing_reg <= 1'b0;
        end
        else if (cmd.adj_clear)
        begin
            sing_reg <= {{(DW-mi4_pkg::THR_W){1'b0}}, threshold} >= adet;
        end
    end

    logic signed [AW-1:0] adj_full;
    assign adj_full = adj_acc_reg + aprod_reg;
    assign adj_mag = adj_full[AW-1] ? AW'(-adj_full) : adj_full;
    assign numer = {adj_mag, {mi4_pkg::SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            res_neg_reg <= adj_full[AW-1] != det_neg;
        end
    end

    mi4_divider u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .numerator(numer),
        .divisor(adet),
        .busy(div_busy),
        .done(div_done),
        .quotient(quo)
    );

    assign lim = res_neg_reg ? QW'({1'b1, {(RW-1){1'b0}}}) : QW'({1'b0, {(RW-1){1'b1}}});

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            opos_reg <= out_position;
            osing_reg <= cmd.out_singular;
            last_reg <= cmd.out_last;
            if (cmd.out_singular)
            begin
                val_reg <= '0;
                sat_reg <= 1'b0;
            end
            else if (quo > lim)
            begin
                val_reg <= res_neg_reg ? RW'(-lim) : RW'(lim);
                sat_reg <= 1'b1;
            end
            else
            begin
                val_reg <= res_neg_reg ? RW'(-quo) : RW'(quo);
                sat_reg <= 1'b0;
            end
        end
    end

    assign status.singular = sing_reg;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign inverse_element = val_reg;
    assign result_position = opos_reg;
    assign singular = osing_reg;
    assign saturated = sat_reg;
    assign last = last_reg;
endmodule

### hw/rtl/mi4_control.sv
`timescale 1ns / 1ps
module mi4_control (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [3:0]        in_position,
    output logic              in_ready,
    output logic              store_we,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        out_position,
    output mi4_pkg::cmd_t     cmd,
    input  mi4_pkg::status_t  status
);
    mi4_pkg::state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] term_reg, term_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mi4_pkg::ST_LOAD;
            idx_reg <= '0;
            term_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            term_reg <= term_next;
            ov_reg <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        term_next = term_reg;
        ov_next = ov_reg;
        cmd = '0;
        cmd.det_term = term_reg;
        cmd.adj_index = idx_reg;
        cmd.adj_term = term_reg[1:0];
        cmd.out_last = (idx_reg == 4'd15);
        in_ready = 1'b0;
        store_we = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            mi4_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    store_we = 1'b1;
                    if (in_position == 4'd15)
                    begin
                        state_next = mi4_pkg::ST_DET_A;
                        term_next = '0;
                        cmd.det_clear = 1'b1;
                    end
                end
            end
            mi4_pkg::ST_DET_A:
            begin
                cmd.det_mul = 1'b1;
                state_next = mi4_pkg::ST_DET_B;
            end
            mi4_pkg::ST_DET_B:
            begin
                cmd.det_acc = 1'b1;
                state_next = mi4_pkg::ST_DET_DONE;
            end
            mi4_pkg::ST_DET_DONE:
            begin
                cmd.det_latch = 1'b1;
                if (term_reg == 3'd5)
                begin
                    state_next = mi4_pkg::ST_ADJ_A;
                    term_next = '0;
                    idx_next = '0;
                end
                else
                begin
                    term_next = term_reg + 3'd1;
                    state_next = mi4_pkg::ST_DET_A;
                end
            end
            mi4_pkg::ST_ADJ_A:
            begin
                if (idx_reg == 4'd0 && term_reg == 3'd0 && !cmd.det_latch)
                begin
                    cmd.adj_clear = 1'b1;
                end
                if (status.singular && !(idx_reg == 4'd0 && term_reg == 3'd0))
                begin
                    state_next = mi4_pkg::ST_SING;
                end
                else
                begin
                    cmd.adj_mul = 1'b1;
                    cmd.adj_clear = (term_reg == 3'd0);
                    state_next = mi4_pkg::ST_ADJ_B;
                end
            end
            mi4_pkg::ST_ADJ_B:
            begin
                cmd.adj_acc = 1'b1;
                if (term_reg == 3'd2)
                begin
                    state_next = mi4_pkg::ST_DIV_START;
                end
                else
                begin
                    term_next = term_reg + 3'd1;
                    state_next = mi4_pkg::ST_ADJ_A;
                end
            end
            mi4_pkg::ST_DIV_START:
            begin
                if (status.singular)
                begin
                    state_next = mi4_pkg::ST_SING;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = mi4_pkg::ST_DIV_WAIT;
                end
            end
            mi4_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = mi4_pkg::ST_EMIT;
                end
            end
            mi4_pkg::ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    if (idx_reg == 4'd15)
                    begin
                        state_next = mi4_pkg::ST_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                        term_next = '0;
                        state_next = mi4_pkg::ST_ADJ_A;
                    end
                end
            end
            mi4_pkg::ST_SING:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_singular = 1'b1;
                    ov_next = 1'b1;
                    if (idx_reg == 4'd15)
                    begin
                        state_next = mi4_pkg::ST_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = mi4_pkg::ST_LOAD;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_position = idx_reg;
endmodule

### hw/rtl/matrix_inverse_4x4_unit.sv
`timescale 1ns / 1ps
// Elements are accepted only in the load state; position 15 starts an inversion. The
// determinant is accumulated via DET_A, DET_B and DET_DONE. Each of the 16 results then
// builds its cofactor via ADJ_A and ADJ_B, starts the shared restoring divider, waits
// for its 79 quotient bits and loads the output register. A singular matrix yields its
// 16 zero results at one per cycle while res_out is ready. Reset is asynchronous and
// active low; it clears control state and the threshold.
module matrix_inverse_4x4_unit (
    input  logic      clk,
    input  logic      rst_n,
    mi4_elem_if.sink  elem_in,
    mi4_res_if.source res_out,
    mi4_cfg_if.sink   cfg
);
    logic [mi4_pkg::THR_W-1:0] thr_reg;
    mi4_pkg::cmd_t    cmd;
    mi4_pkg::status_t status;
    logic             store_we;
    logic [3:0]       out_position;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.data;
        end
    end

    mi4_control u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(elem_in.valid),
        .in_position(elem_in.element_position),
        .in_ready(elem_in.ready),
        .store_we(store_we),
        .out_valid(res_out.valid),
        .out_ready(res_out.ready),
        .out_position(out_position),
        .cmd(cmd),
        .status(status)
    );

    mi4_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .store_we(store_we),
        .store_addr(elem_in.element_position),
        .store_data(elem_in.element_value),
        .threshold(thr_reg),
        .out_position(out_position),
        .cmd(cmd),
        .status(status),
        .inverse_element(res_out.inverse_element),
        .result_position(res_out.result_position),
        .singular(res_out.singular),
        .saturated(res_out.saturated),
        .last(res_out.last)
    );
endmodule

### sim/tb_matrix_inverse_4x4_unit.sv
`timescale 1ns / 1ps
module tb_matrix_inverse_4x4_unit;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 370;
    localparam logic [mi4_pkg::THR_W-1:0] THR_MAX = {mi4_pkg::THR_W{1'b1}};

    typedef struct {
        logic signed [mi4_pkg::RES_W-1:0] value;
        logic [3:0]              position;
        logic                    singular;
        logic                    saturated;
        logic                    last;
    } inverse_result_t;

    logic clk;
    logic rst_n;

    mi4_elem_if elem_in();
    mi4_res_if  res_out();
    mi4_cfg_if  cfg();

    matrix_inverse_4x4_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .elem_in(elem_in.sink),
        .res_out(res_out.source),
        .cfg(cfg.sink)
    );

    logic signed [mi4_pkg::ELEM_W-1:0] matrix_shadow [16];
    logic [mi4_pkg::THR_W-1:0] threshold_shadow;
    inverse_result_t          pending_inverse [$];
    int                       error_count;
    int                       cycle_count;
    int                       items_sent;
    int                       results_checked;
    int                       inversions;
    int                       singular_seen;
    int                       saturated_seen;
    bit                       no_idle;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        res_out.ready <= rst_n && (no_idle || $urandom_range(99) >= 12);
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    always @(negedge clk)
    begin
        inverse_result_t want;
        if (rst_n && res_out.valid && res_out.ready)
        begin
            results_checked++;
            if (pending_inverse.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result at position %0d",
                    res_out.result_position));
            end
            else
            begin
                want = pending_inverse.pop_front();
                if (res_out.inverse_element !== want.value)
                    report_mismatch($sformatf("pos %0d value %0d, want %0d", want.position,
                        res_out.inverse_element, want.value));
                if (res_out.result_position !== want.position)
                    report_mismatch($sformatf("position %0d, want %0d",
                        res_out.result_position, want.position));
                if (res_out.singular !== want.singular)
                    report_mismatch($sformatf("pos %0d singular %b, want %b", want.position,
                        res_out.singular, want.singular));
                if (res_out.saturated !== want.saturated)
                    report_mismatch($sformatf("pos %0d saturated %b, want %b", want.position,
                        res_out.saturated, want.saturated));
                if (res_out.last !== want.last)
                    report_mismatch($sformatf("pos %0d last %b, want %b", want.position,
                        res_out.last, want.last));
            end
        end
    end

    function automatic logic signed [127:0] cofactor_of(input int row, input int col);
        longint m [3][3];
        longint d3;
        int     r;
        int     c;
        int     mr;
        int     mc;
        mr = 0;
        for (r = 0; r < 4; r++)
        begin
            if (r != row)
            begin
                mc = 0;
                for (c = 0; c < 4; c++)
                begin
                    if (c != col)
                    begin
                        m[mr][mc] = longint'(matrix_shadow[r * 4 + c]);
                        mc++;
                    end
                end
                mr++;
            end
        end
        d3 = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
           - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
           + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
        if (((row + col) % 2) == 1)
            d3 = -d3;
        return 128'(signed'(d3));
    endfunction

    // The adjugate is the transposed cofactor matrix; the determinant is
    // the first row expanded against its cofactors, exact in 128 bits.
    task automatic predict_inverse();
        logic signed [127:0] adjugate [16];
        logic signed [127:0] det;
        logic [127:0]        det_mag;
        logic [127:0]        numer;
        logic [127:0]        quot;
        logic [127:0]        limit;
        logic                is_singular;
        logic                neg;
        inverse_result_t     res;
        int                  i;
        int                  j;
        for (i = 0; i < 4; i++)
            for (j = 0; j < 4; j++)
                adjugate[i * 4 + j] = cofactor_of(j, i);
        det = '0;
        for (j = 0; j < 4; j++)
            det += 128'(signed'(matrix_shadow[j])) * adjugate[j * 4];
        det_mag = det[127] ? -det : det;
        is_singular = {80'd0, threshold_shadow} >= det_mag;
        inversions++;
        if (is_singular)
            singular_seen++;
        for (i = 0; i < 16; i++)
        begin
            res.value = '0;
            res.position = 4'(i);
            res.singular = is_singular;
            res.saturated = 1'b0;
            res.last = (i == 15);
            if (!is_singular)
            begin
                neg = adjugate[i][127] != det[127];
                numer = adjugate[i][127] ? -adjugate[i] : adjugate[i];
                numer = numer << mi4_pkg::SHIFT;
                quot = numer / det_mag;
                limit = neg ? (128'd1 << (mi4_pkg::RES_W - 1))
                            : ((128'd1 << (mi4_pkg::RES_W - 1)) - 1);
                if (quot > limit)
                begin
                    quot = limit;
                    res.saturated = 1'b1;
                    saturated_seen++;
                end
                res.value = neg ? mi4_pkg::RES_W'(-quot) : mi4_pkg::RES_W'(quot);
            end
            pending_inverse.push_back(res);
        end
    endtask

    task automatic send_element(input logic signed [mi4_pkg::ELEM_W-1:0] value,
                                input logic [3:0] position);
        bit ready_seen;
        while (!no_idle && $urandom_range(99) < 12)
        begin
            elem_in.valid <= 1'b0;
            @(posedge clk);
        end
        elem_in.valid <= 1'b1;
        elem_in.element_value <= value;
        elem_in.element_position <= position;
        forever
        begin
            @(negedge clk);
            ready_seen = elem_in.ready;
            @(posedge clk);
            if (ready_seen)
                break;
        end
        items_sent++;
        matrix_shadow[position] = value;
        if (position == 4'd15)
            predict_inverse();
    endtask

    task automatic send_matrix(input logic signed [mi4_pkg::ELEM_W-1:0] m [16]);
        int k;
        for (k = 0; k < 16; k++)
            send_element(m[k], 4'(k));
    endtask

    task automatic wait_drained();
        elem_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_inverse.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [mi4_pkg::THR_W-1:0] value);
        bit ready_seen;
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        forever
        begin
            @(negedge clk);
            ready_seen = cfg.ready;
            @(posedge clk);
            if (ready_seen)
                break;
        end
        threshold_shadow = value;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void make_diagonal(output logic signed [mi4_pkg::ELEM_W-1:0] m [16],
                                          input logic signed [mi4_pkg::ELEM_W-1:0] d);
        int k;
        for (k = 0; k < 16; k++)
            m[k] = (k % 5 == 0) ? d : '0;
    endfunction

    task automatic test_identity();
        logic signed [mi4_pkg::ELEM_W-1:0] m [16];
        make_diagonal(m, 16'sd4096);
        send_matrix(m);
        make_diagonal(m, -16'sd32768);
        send_matrix(m);
    endtask

    task automatic test_extremes();
        logic signed [mi4_pkg::ELEM_W-1:0] m [16];
        int k;
        for (k = 0; k < 16; k++)
            m[k] = (k % 5 == 0) ? 16'sh7FFF : ((k % 3 == 0) ? -16'sd32768 : 16'sd1);
        send_matrix(m);
    endtask

    task automatic test_singular();
        logic signed [mi4_pkg::ELEM_W-1:0] m [16];
        int k;
        for (k = 0; k < 16; k++)
            m[k] = '0;
        send_matrix(m);
        for (k = 0; k < 16; k++)
            m[k] = (k < 4) ? m[k] : 16'($urandom);
        for (k = 0; k < 4; k++)
            m[k] = m[k + 8];
        send_matrix(m);
    endtask

    task automatic test_saturation();
        logic signed [mi4_pkg::ELEM_W-1:0] m [16];
        make_diagonal(m, 16'sd1);
        m[0] = 16'sd100;
        m[1] = 16'sd99;
        m[4] = 16'sd1;
        m[5] = 16'sd1;
        send_matrix(m);
        make_diagonal(m, 16'sd1);
        send_matrix(m);
    endtask

    task automatic test_threshold();
        logic signed [mi4_pkg::ELEM_W-1:0] m [16];
        write_threshold(THR_MAX);
        make_diagonal(m, 16'sd4096);
        send_matrix(m);
        send_element(16'sd4095, 4'd15);
        write_threshold(48'd4096 * 48'd4096 * 48'd4096 * 48'd4095);
        send_element(16'sd4095, 4'd15);
        send_element(16'sd4096, 4'd15);
        write_threshold('0);
    endtask

    task automatic test_random();
        logic signed [mi4_pkg::ELEM_W-1:0] m [16];
        int k;
        int kind;
        int phase;
        int span;
        int target;
        phase = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ((items_sent % 100) < 16)
            begin
                phase++;
                no_idle = (phase == 3);
                case (phase % 4)
                    0: write_threshold('0);
                    1: write_threshold(48'($urandom_range(1 << 20)));
                    2: write_threshold({16'd0, 32'($urandom)});
                    default: write_threshold(48'({$urandom, $urandom}));
                endcase
            end
            kind = $urandom_range(99);
            span = ($urandom_range(3) == 0) ? 32767 : 1 << $urandom_range(12);
            for (k = 0; k < 16; k++)
                m[k] = ($urandom_range(7) == 0) ? 16'($urandom)
                     : 16'(signed'($urandom_range(2 * span)) - span);
            if (kind < 10)
                for (k = 0; k < 4; k++)
                    m[12 + k] = m[4 + k];
            if (kind < 75)
            begin
                send_matrix(m);
            end
            else if (kind < 92)
            begin
                repeat ($urandom_range(1, 4))
                    send_element(m[$urandom_range(14)], 4'($urandom_range(14)));
                send_element(m[15], 4'd15);
            end
            else
            begin
                send_element(m[0], 4'($urandom_range(14)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        items_sent = 0;
        results_checked = 0;
        inversions = 0;
        singular_seen = 0;
        saturated_seen = 0;
        no_idle = 1'b0;
        threshold_shadow = '0;
        rst_n <= 1'b0;
        elem_in.valid <= 1'b0;
        elem_in.element_value <= '0;
        elem_in.element_position <= '0;
        cfg.valid <= 1'b0;
        cfg.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_threshold('0);
        test_identity();
        test_extremes();
        test_singular();
        test_saturation();
        test_threshold();
        test_random();
        wait_drained();
        $display("Sent %0d elements, %0d inversions, %0d results checked.",
            items_sent, inversions, results_checked);
        $display("Singular matrices: %0d, saturated elements: %0d.",
            singular_seen, saturated_seen);
        if (error_count == 0 && pending_inverse.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
